[hdl/eah_pkg.sv]
package eah_pkg;

   // Table geometry.
   localparam int MAX_LAYERS  = 64;
   localparam int MAX_EXPERTS = 256;
   localparam int WORD_W      = 64;

   localparam int LAYER_W  = $clog2(MAX_LAYERS);
   localparam int EXPERT_W = $clog2(MAX_EXPERTS);
   localparam int BIT_W    = $clog2(WORD_W);
   localparam int WSEL_W   = EXPERT_W - BIT_W;
   localparam int ROW_W    = LAYER_W + WSEL_W;
   localparam int DEPTH    = 1 << ROW_W;

   // Counts that must be able to hold the maximum itself.
   localparam int LCNT_W   = $clog2(MAX_LAYERS + 1);
   localparam int ECNT_W   = $clog2(MAX_EXPERTS + 1);
   localparam int ROWCNT_W = LCNT_W + WSEL_W;
   localparam int POP_W    = $clog2(WORD_W + 1);
   localparam int BYTES    = WORD_W / 8;

   // Result field widths.
   localparam int TOTAL_W = 64;
   localparam int SUM_W   = 15;

   // Control and status registers.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LAYERS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_EXPERTS = 1'd1;
   localparam logic [LCNT_W-1:0] ACTIVE_LAYERS_RST  = LCNT_W'(64);
   localparam logic [ECNT_W-1:0] ACTIVE_EXPERTS_RST = ECNT_W'(256);

   // Word kinds.
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic              valid;
      logic              last_word;
      logic              final_row;
      logic [WSEL_W-1:0] word_sel;
   } scan_tag_type;

   typedef struct packed {
      logic              seen;
      logic [ECNT_W-1:0] lo;
      logic [ECNT_W-1:0] hi;
      logic [SUM_W-1:0]  total;
      logic [SUM_W-1:0]  slots;
   } scan_sum_type;

   // Population count as per-byte counts followed by a sum of the bytes.
   function automatic logic [POP_W-1:0] popcount_word(input word_type w);
      logic [3:0]       byte_cnt [BYTES];
      logic [POP_W-1:0] sum;
      for (int b = 0; b < BYTES; b++) begin
         byte_cnt[b] = '0;
         for (int i = 0; i < 8; i++) begin
            byte_cnt[b] = byte_cnt[b] + 4'(w[8*b+i]);
         end
      end
      sum = '0;
      for (int b = 0; b < BYTES; b++) begin
         sum = sum + POP_W'(byte_cnt[b]);
      end
      return sum;
   endfunction

endpackage

[hdl/eah_map.sv]
module eah_map (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  eah_pkg::row_type  rd_addr,
   output eah_pkg::word_type rd_data,
   input  logic              wr_en,
   input  eah_pkg::row_type  wr_addr,
   input  eah_pkg::word_type wr_data
);
   import eah_pkg::*;

   word_type         mem [DEPTH];
   logic [DEPTH-1:0] row_vld_ff;
   word_type         rd_data_ff;
   logic             rd_vld_ff;

   // A row that has never been written reads as all zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= row_vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

[hdl/eah_scan.sv]
module eah_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [eah_pkg::ECNT_W-1:0]  ne,
   input  eah_pkg::scan_tag_type       tag,
   input  eah_pkg::word_type           data,
   output logic                        done,
   output eah_pkg::scan_sum_type       sum
);
   import eah_pkg::*;

   word_type          mask;
   logic              s1_valid_ff;
   logic              s1_first_ff;
   logic              s1_last_ff;
   logic              s1_final_ff;
   logic [POP_W-1:0]  s1_pop_ff;
   logic [ECNT_W-1:0] layer_acc_ff;
   logic [ECNT_W-1:0] layer_acc_in;
   logic              s2_valid_ff;
   logic              s2_final_ff;
   logic              done_ff;
   scan_sum_type      sum_ff;
   scan_sum_type      sum_in;

   // Experts at or above the active count do not take part.
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         mask[i] = ECNT_W'({tag.word_sel, BIT_W'(i)}) < ne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_final_ff <= 1'b0;
      end else begin
         s1_valid_ff <= tag.valid;
         s2_valid_ff <= s1_valid_ff && s1_last_ff;
         s2_final_ff <= s1_valid_ff && s1_final_ff;
      end
      s1_first_ff <= tag.word_sel == '0;
      s1_last_ff  <= tag.last_word;
      s1_final_ff <= tag.final_row;
      s1_pop_ff   <= popcount_word(data & mask);
      if (s1_valid_ff) begin
         layer_acc_ff <= layer_acc_in;
      end
   end

   assign layer_acc_in = (s1_first_ff ? '0 : layer_acc_ff) + ECNT_W'(s1_pop_ff);

   always_comb begin
      sum_in = sum_ff;
      if (start) begin
         sum_in = '0;
      end else if (s2_valid_ff && layer_acc_ff != '0) begin
         if (!sum_ff.seen || layer_acc_ff < sum_ff.lo) begin
            sum_in.lo = layer_acc_ff;
         end
         if (!sum_ff.seen || layer_acc_ff > sum_ff.hi) begin
            sum_in.hi = layer_acc_ff;
         end
         sum_in.seen  = 1'b1;
         sum_in.total = sum_ff.total + SUM_W'(layer_acc_ff);
         sum_in.slots = sum_ff.slots + SUM_W'(ne);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         done_ff <= s2_valid_ff && s2_final_ff;
      end
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

[hdl/expert_activation_histogram.sv]
// Record words: one accepted per cycle, back to back, while no report is in progress; the
// touched bit is written at the edge after acceptance. A report word that arrives before
// anything was recorded is absorbed at once. Any other report walks the L effective active
// layers (one 64-bit row read per cycle), or none when L is zero, then gives its result. No
// word is taken until the result reaches the output register, which a held result keeps busy.
// Reset (synchronous, active high) clears all touched bits at once through per-row valid
// bits, zeroes the activation total and restores both registers to their full sizes.
module expert_activation_histogram (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [eah_pkg::LAYER_W-1:0]       req_layer,
   input  logic [eah_pkg::EXPERT_W-1:0]      req_expert,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [eah_pkg::TOTAL_W-1:0]       rsp_activation_total,
   output logic [eah_pkg::ECNT_W-1:0]        rsp_fewest_touched,
   output logic [eah_pkg::ECNT_W-1:0]        rsp_most_touched,
   output logic [eah_pkg::SUM_W-1:0]         rsp_touched_cells,
   output logic [eah_pkg::SUM_W-1:0]         rsp_slot_count,
   output logic                              rsp_any_layer_seen,
   // Configuration channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [eah_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eah_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import eah_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type           state_ff;
   logic [LCNT_W-1:0]   act_layers_ff;
   logic [ECNT_W-1:0]   act_experts_ff;
   logic [LCNT_W-1:0]   nl;
   logic [ECNT_W-1:0]   ne;
   logic [TOTAL_W-1:0]  count_ff;
   logic                ever_ff;

   logic                req_acc;
   logic                rec_acc;
   logic                rep_acc;
   logic                rec_hit;

   // Record pipeline: the read is issued on acceptance, the write follows in the next cycle.
   logic                p1_valid_ff;
   row_type             p1_row_ff;
   logic [BIT_W-1:0]    p1_bit_ff;
   logic                fwd_valid_ff;
   row_type             fwd_row_ff;
   word_type            fwd_data_ff;
   word_type            merge_base;
   word_type            wr_data;

   logic [ROWCNT_W-1:0] scan_cnt_ff;
   logic [ROWCNT_W-1:0] scan_end;
   logic                scan_issue;
   scan_tag_type        scan_tag_in;
   scan_tag_type        scan_tag_ff;
   logic                scan_start;
   logic                scan_done;
   scan_sum_type        scan_sum;

   logic                rd_en;
   row_type             rd_addr;
   word_type            rd_data;

   logic                rsp_valid_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   scan_sum_type        rsp_sum_ff;
   logic                emit_go;

   // Register values above the table size are clamped to it.
   assign nl = (act_layers_ff > LCNT_W'(MAX_LAYERS)) ? LCNT_W'(MAX_LAYERS) : act_layers_ff;
   assign ne = (act_experts_ff > ECNT_W'(MAX_EXPERTS)) ? ECNT_W'(MAX_EXPERTS) : act_experts_ff;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_layers_ff  <= ACTIVE_LAYERS_RST;
         act_experts_ff <= ACTIVE_EXPERTS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_LAYERS: begin
               act_layers_ff <= csr_wdata[LCNT_W-1:0];
            end
            CSR_ACTIVE_EXPERTS: begin
               act_experts_ff <= csr_wdata[ECNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Words are taken whenever no report is in progress; a finished report waiting in the
   // output register does not hold back records.
   assign req_ready = state_ff == ST_IDLE;
   assign req_acc   = req_valid && req_ready;
   assign rec_acc   = req_acc && req_kind == KIND_RECORD;
   assign rep_acc   = req_acc && req_kind == KIND_REPORT;
   assign rec_hit   = LCNT_W'(req_layer) < nl && ECNT_W'(req_expert) < ne;

   // The activation total and the recorded flag. A record with no active layers leaves the
   // flag alone; an out-of-range record still sets it.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ever_ff  <= 1'b0;
      end else if (rec_acc) begin
         if (rec_hit) begin
            count_ff <= count_ff + TOTAL_W'(1);
         end
         if (nl != '0) begin
            ever_ff <= 1'b1;
         end
      end
   end

   // Second half of the read-modify-write. A write issued in the previous cycle to the
   // same row has not reached the read data, so it is forwarded from a holding register.
   assign merge_base = (fwd_valid_ff && fwd_row_ff == p1_row_ff) ? fwd_data_ff : rd_data;
   assign wr_data    = merge_base | (WORD_W'(1) << p1_bit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= rec_acc && rec_hit;
         fwd_valid_ff <= p1_valid_ff;
      end
      p1_row_ff   <= {req_layer, req_expert[EXPERT_W-1 -: WSEL_W]};
      p1_bit_ff   <= req_expert[BIT_W-1:0];
      fwd_row_ff  <= p1_row_ff;
      fwd_data_ff <= wr_data;
   end

   // The report walks the map row by row, layer-major, over the active layers only.
   assign scan_end   = {nl, WSEL_W'(0)};
   assign scan_issue = state_ff == ST_SCAN && scan_cnt_ff < scan_end;
   assign scan_start = rep_acc && ever_ff;

   always_comb begin
      scan_tag_in.valid     = scan_issue;
      scan_tag_in.word_sel  = scan_cnt_ff[WSEL_W-1:0];
      scan_tag_in.last_word = &scan_cnt_ff[WSEL_W-1:0];
      scan_tag_in.final_row = scan_cnt_ff == scan_end - ROWCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_tag_ff <= '0;
      end else begin
         scan_tag_ff <= scan_tag_in;
      end
   end

   // The record path and the scan never read in the same cycle.
   assign rd_en   = (rec_acc && rec_hit) || scan_issue;
   assign rd_addr = scan_issue ? scan_cnt_ff[ROW_W-1:0]
                               : {req_layer, req_expert[EXPERT_W-1 -: WSEL_W]};

   eah_map u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_row_ff),
      .wr_data (wr_data)
   );

   eah_scan u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .ne    (ne),
      .tag   (scan_tag_ff),
      .data  (rd_data),
      .done  (scan_done),
      .sum   (scan_sum)
   );

   // The summary moves to the output register once that register is free or being drained.
   assign emit_go = state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready);

   // Control sequence and output register. A report before any record is consumed
   // without a result. With no active layers the cleared summary is sent at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               scan_cnt_ff <= '0;
               if (scan_start) begin
                  state_ff <= (nl == '0) ? ST_EMIT : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_issue) begin
                  scan_cnt_ff <= scan_cnt_ff + ROWCNT_W'(1);
               end
               if (scan_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_total_ff <= count_ff;
                  rsp_sum_ff   <= scan_sum;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_activation_total = rsp_total_ff;
   assign rsp_fewest_touched   = rsp_sum_ff.lo;
   assign rsp_most_touched     = rsp_sum_ff.hi;
   assign rsp_touched_cells    = rsp_sum_ff.total;
   assign rsp_slot_count       = rsp_sum_ff.slots;
   assign rsp_any_layer_seen   = rsp_sum_ff.seen;

   // No record write may still be pending once the walk of the map has begun.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !p1_valid_ff)
      else $error("record write pending during report walk");

   // The summary unit finishes only while a walk is in progress.
   assert property (@(posedge clock) disable iff (reset)
      scan_done |-> state_ff == ST_SCAN)
      else $error("summary finished outside a walk");

   // A new result is loaded only on leaving the emit state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside the emit state");

   // A reported layer range is ordered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sum_ff.seen |-> rsp_sum_ff.hi >= rsp_sum_ff.lo)
      else $error("most touched below fewest touched");

endmodule

[verif/expert_activation_histogram_tb.sv]
module expert_activation_histogram_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import eah_pkg::*;

   // A report can walk all 64 layers after its word is accepted, so SETTLE_CYCLES
   // quiet cycles are allowed before the registers are rewritten or the run ends.
   localparam int SETTLE_CYCLES = 300;
   // Length of the deliberate hold-off on the result channel, in cycles.
   localparam int HOLD_CYCLES   = 2000;

   // One word on the input channel.
   typedef struct {
      logic                kind;
      logic [LAYER_W-1:0]  layer;
      logic [EXPERT_W-1:0] expert;
   } hist_word_type;

   // One word on the result channel.
   typedef struct {
      logic [TOTAL_W-1:0] activation_total;
      logic [ECNT_W-1:0]  fewest_touched;
      logic [ECNT_W-1:0]  most_touched;
      logic [SUM_W-1:0]   touched_cells;
      logic [SUM_W-1:0]   slot_count;
      logic               any_layer_seen;
   } report_type;

   // Clock, reset and every input of the block start at a known value.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_kind  = KIND_RECORD;
   logic [LAYER_W-1:0]    req_layer  = '0;
   logic [EXPERT_W-1:0]   req_expert = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [TOTAL_W-1:0]    rsp_activation_total;
   logic [ECNT_W-1:0]     rsp_fewest_touched;
   logic [ECNT_W-1:0]     rsp_most_touched;
   logic [SUM_W-1:0]      rsp_touched_cells;
   logic [SUM_W-1:0]      rsp_slot_count;
   logic                  rsp_any_layer_seen;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ACTIVE_LAYERS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Words waiting to be offered, and the reports the block owes us, oldest first.
   hist_word_type pending_words [$];
   report_type    expected_reports [$];

   int unsigned words_queued   = 0;
   int unsigned words_accepted = 0;
   int unsigned mismatches     = 0;
   int unsigned idle_pct       = 34;
   int unsigned hold_token     = 0;

   // Our own copy of the block's state and registers.
   bit                touched [MAX_LAYERS][MAX_EXPERTS];
   logic [63:0]       activation_count = '0;
   bit                ever_recorded    = 1'b0;
   logic [LCNT_W-1:0] cfg_layers       = ACTIVE_LAYERS_RST;
   logic [ECNT_W-1:0] cfg_experts      = ACTIVE_EXPERTS_RST;

   expert_activation_histogram u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_layer            (req_layer),
      .req_expert           (req_expert),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_activation_total (rsp_activation_total),
      .rsp_fewest_touched   (rsp_fewest_touched),
      .rsp_most_touched     (rsp_most_touched),
      .rsp_touched_cells    (rsp_touched_cells),
      .rsp_slot_count       (rsp_slot_count),
      .rsp_any_layer_seen   (rsp_any_layer_seen),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5ns clock = ~clock;

   // Register values above the table size are clamped to it.
   function automatic int unsigned eff_layers();
      return (cfg_layers > MAX_LAYERS) ? MAX_LAYERS : cfg_layers;
   endfunction

   function automatic int unsigned eff_experts();
      return (cfg_experts > MAX_EXPERTS) ? MAX_EXPERTS : cfg_experts;
   endfunction

   // Applies one accepted word to the shadow table. A record word marks its cell if it lies
   // inside the table in use; a report word scans the table and queues the report it owes.
   function automatic void apply_word(input hist_word_type w);
      int unsigned nl;
      int unsigned ne;
      int unsigned cnt;
      int unsigned lo;
      int unsigned hi;
      int unsigned total;
      int unsigned slots;
      bit          seen;
      report_type  r;
      nl = eff_layers();
      ne = eff_experts();
      if (w.kind == KIND_RECORD) begin
         // Even an out-of-range record counts as having recorded, unless no layers are in use.
         if (nl != 0) ever_recorded = 1'b1;
         if (w.layer < nl && w.expert < ne) begin
            touched[w.layer][w.expert] = 1'b1;
            activation_count = activation_count + 64'd1;
         end
      end else if (ever_recorded) begin
         lo = 0;
         hi = 0;
         total = 0;
         slots = 0;
         seen = 1'b0;
         for (int l = 0; l < nl; l++) begin
            cnt = 0;
            for (int e = 0; e < ne; e++) cnt += touched[l][e];
            if (cnt != 0) begin
               if (!seen || cnt < lo) lo = cnt;
               if (!seen || cnt > hi) hi = cnt;
               seen = 1'b1;
               total += cnt;
               slots += ne;
            end
         end
         r.activation_total = activation_count;
         r.fewest_touched   = ECNT_W'(lo);
         r.most_touched     = ECNT_W'(hi);
         r.touched_cells    = SUM_W'(total);
         r.slot_count       = SUM_W'(slots);
         r.any_layer_seen   = seen;
         expected_reports.push_back(r);
      end
   endfunction

   task automatic push_word(input logic kind, input int unsigned layer,
                            input int unsigned expert);
      hist_word_type w;
      w.kind   = kind;
      w.layer  = LAYER_W'(layer);
      w.expert = EXPERT_W'(expert);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Mostly records that land inside the table in use, with some that land anywhere and a
   // sprinkling of reports.
   task automatic queue_random(input int unsigned count);
      int unsigned nl;
      int unsigned ne;
      hist_word_type w;
      nl = eff_layers();
      ne = eff_experts();
      repeat (count) begin
         w.kind   = ($urandom_range(99) < 12) ? KIND_REPORT : KIND_RECORD;
         w.layer  = LAYER_W'($urandom);
         w.expert = EXPERT_W'($urandom);
         if (w.kind == KIND_RECORD && nl != 0 && ne != 0 && $urandom_range(99) < 80) begin
            w.layer  = LAYER_W'($urandom_range(nl - 1));
            w.expert = EXPERT_W'($urandom_range(ne - 1));
         end
         pending_words.push_back(w);
         words_queued++;
      end
   endtask

   // Returns at a rising edge once every queued word has been accepted and every expected
   // report has arrived, after a further number of quiet cycles.
   task automatic wait_idle(input int unsigned settle);
      do @(posedge clock);
      while (words_accepted != words_queued || expected_reports.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Writes both registers back to back over the configuration channel. It is called at a
   // rising edge with the block idle, so the shadow registers can follow each handshake.
   task automatic write_config(input int unsigned layers, input int unsigned experts);
      csr_valid <= 1'b1;
      csr_index <= CSR_ACTIVE_LAYERS;
      csr_wdata <= CSR_DATA_W'(layers);
      do @(posedge clock);
      while (!csr_ready);
      cfg_layers = LCNT_W'(layers);
      csr_index <= CSR_ACTIVE_EXPERTS;
      csr_wdata <= CSR_DATA_W'(experts);
      do @(posedge clock);
      while (!csr_ready);
      cfg_experts = ECNT_W'(experts);
      csr_valid <= 1'b0;
   endtask

   // Driver. Values read just after the edge are those from before it, so a handshake seen
   // here is the one that took place at this edge. Each signal gets at most one assignment.
   always @(posedge clock) begin : driver
      hist_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            w.kind   = req_kind;
            w.layer  = req_layer;
            w.expert = req_expert;
            apply_word(w);
            words_accepted++;
         end
         // A new word is offered only once the previous one has gone.
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               w = pending_words.pop_front();
               req_kind   <= w.kind;
               req_layer  <= w.layer;
               req_expert <= w.expert;
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each accepted report is checked against the oldest expectation. A fresh hold
   // token makes it refuse results for a long stretch, which it counts down itself.
   always @(posedge clock) begin : monitor
      int unsigned hold_seen;
      int unsigned hold_left;
      report_type  exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen = hold_token;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("report word arrived with none expected");
               mismatches++;
            end else begin
               exp_r = expected_reports.pop_front();
               if (rsp_activation_total !== exp_r.activation_total) begin
                  $error("activation_total: expected %0d, actual %0d",
                         exp_r.activation_total, rsp_activation_total);
                  mismatches++;
               end
               if (rsp_fewest_touched !== exp_r.fewest_touched) begin
                  $error("fewest_touched: expected %0d, actual %0d",
                         exp_r.fewest_touched, rsp_fewest_touched);
                  mismatches++;
               end
               if (rsp_most_touched !== exp_r.most_touched) begin
                  $error("most_touched: expected %0d, actual %0d",
                         exp_r.most_touched, rsp_most_touched);
                  mismatches++;
               end
               if (rsp_touched_cells !== exp_r.touched_cells) begin
                  $error("touched_cells: expected %0d, actual %0d",
                         exp_r.touched_cells, rsp_touched_cells);
                  mismatches++;
               end
               if (rsp_slot_count !== exp_r.slot_count) begin
                  $error("slot_count: expected %0d, actual %0d",
                         exp_r.slot_count, rsp_slot_count);
                  mismatches++;
               end
               if (rsp_any_layer_seen !== exp_r.any_layer_seen) begin
                  $error("any_layer_seen: expected %0d, actual %0d",
                         exp_r.any_layer_seen, rsp_any_layer_seen);
                  mismatches++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Stimulus. Registers are only rewritten once the block has gone quiet.
   initial begin : stimulus
      int unsigned phase_layers  [8] = '{64, 1, 127, 8, 0, 64, 33, 64};
      int unsigned phase_experts [8] = '{256, 1, 511, 64, 256, 300, 100, 256};
      int unsigned phase_items   [8] = '{70, 70, 75, 80, 20, 70, 70, 60};
      int unsigned layer_sel;
      int unsigned n_experts;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A report before anything has been recorded gives nothing back.
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);

      // With no layers in use a record does not count as recording, so the report is
      // still silent, and stays so after the full table is restored.
      write_config(0, 256);
      push_word(KIND_RECORD, 3, 3);
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);
      write_config(64, 256);
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);

      // A record outside a small table is ignored but enables reporting, so the first
      // report shows no qualifying layer and a zero total. Then the table's corners.
      write_config(10, 20);
      push_word(KIND_RECORD, 10, 5);
      push_word(KIND_REPORT, 0, 0);
      push_word(KIND_RECORD, 5, 20);
      push_word(KIND_RECORD, 0, 0);
      push_word(KIND_RECORD, 9, 19);
      push_word(KIND_RECORD, 9, 0);
      push_word(KIND_RECORD, 0, 19);
      push_word(KIND_RECORD, 0, 0);
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);

      // Full table, extremes of both fields.
      write_config(64, 256);
      push_word(KIND_RECORD, 63, 255);
      push_word(KIND_RECORD, 63, 0);
      push_word(KIND_RECORD, 0, 255);
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);

      // Register values beyond the table are clamped.
      write_config(100, 300);
      push_word(KIND_RECORD, 40, 128);
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);

      // No experts in use: records are ignored and marked cells outside the table are kept
      // but not counted. Then no layers at all, with reporting already enabled.
      write_config(3, 0);
      push_word(KIND_RECORD, 1, 1);
      push_word(KIND_REPORT, 0, 0);
      wait_idle(SETTLE_CYCLES);
      write_config(0, 256);
      push_word(KIND_REPORT, 0, 0);

      // Random phases over a spread of table sizes. Each phase is sent in two halves, the
      // sender pausing in between until every report owed has come back.
      for (int p = 0; p < 8; p++) begin
         wait_idle(SETTLE_CYCLES);
         layer_sel = phase_layers[p];
         n_experts = phase_experts[p];
         if (p == 7) begin
            layer_sel = $urandom_range(127);
            n_experts = $urandom_range(511);
         end
         write_config(layer_sel, n_experts);
         // One phase runs with no idling on either side.
         idle_pct = (p == 2) ? 0 : 34;
         // In this phase the receiver holds off long enough for the block to back up.
         if (p == 3) hold_token++;
         // Touching every layer of the full table drives the slot count to its largest value.
         if (p == 0) begin
            for (int l = 0; l < MAX_LAYERS; l++) push_word(KIND_RECORD, l, $urandom_range(255));
            push_word(KIND_REPORT, 0, 0);
         end
         queue_random(phase_items[p] / 2);
         wait_idle(0);
         queue_random(phase_items[p] - phase_items[p] / 2);
      end

      wait_idle(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest correct run.
   initial begin : watchdog
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hdl/eah_pkg.sv
hdl/eah_map.sv
hdl/eah_scan.sv
hdl/expert_activation_histogram.sv
verif/expert_activation_histogram_tb.sv
